### hdl/loe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// loe_pkg: shared types, codes and an arithmetic helper
// Payload structs, stage records and saturating add for the estimator.
// ----------------------------------------------------------------------------
package loe_pkg;

   // fixed field widths
   localparam int VAL_W    = 32;
   localparam int ACC_W    = 64;
   localparam int SLOT_W   = 4;
   localparam int ABS_W    = 31;
   localparam int REL_W    = 16;
   localparam int CSR_IDX_W = 2;

   // defaults for the top level parameters
   localparam int DEF_NUM_SLOTS = 16;
   localparam int DEF_FRAC_BITS = 16;

   // register reset values
   localparam logic [VAL_W-1:0] TIME_COEFF_RST = '0;
   localparam logic [ABS_W-1:0] ABS_THRESH_RST = ABS_W'(7);
   localparam logic [REL_W-1:0] REL_THRESH_RST = REL_W'(1311);

   // accumulator and output range limits
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(64'sd2147483648);

   // command codes
   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_EST  = 2'd1,
      CMD_UPD  = 2'd2
   } cmd_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_COEFF = 2'd0,
      CSR_ABS_THRESH = 2'd1,
      CSR_REL_THRESH = 2'd2
   } csr_idx_type;

   // result kinds
   localparam logic KIND_EST = 1'b0;
   localparam logic KIND_UPD = 1'b1;

   // input transaction
   typedef struct packed {
      cmd_type           command;
      logic [SLOT_W-1:0] slot;
      logic [VAL_W-1:0]  dep_value;
      logic [VAL_W-1:0]  coefficient;
      logic [VAL_W-1:0]  time_now;
      logic [VAL_W-1:0]  measured;
      logic              last;
   } req_type;

   // result transaction
   typedef struct packed {
      logic             kind;
      logic [VAL_W-1:0] estimate;
      logic             mismatch;
   } rsp_type;

   // threshold registers
   typedef struct packed {
      logic [ABS_W-1:0] abs_thresh;
      logic [REL_W-1:0] rel_thresh;
   } thr_type;

   // element record entering the accumulate pipe
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             in_range;
      logic             upd;
      logic             last;
      logic [VAL_W-1:0] dep;
      logic [VAL_W-1:0] meas;
      logic [VAL_W-1:0] prev_out;
      logic [VAL_W-1:0] elapsed;
   } elem_type;

   // closing record leaving the accumulate pipe
   typedef struct packed {
      logic             valid;
      logic             upd;
      logic [VAL_W-1:0] meas;
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] tprod;
   } close_type;

   // saturating signed add on accumulator width
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

endpackage
`default_nettype wire

### hdl/linear_output_estimator_top.sv
`default_nettype none
// A closing element passes the s1, s2 and close records, then the s4 and s5 records, then the rsp_valid register.
// Throughput: one transaction per cycle while the pipeline is not held.
// The pipeline holds only while its last stage has a result and rsp is full and stalled.
// Reset (synchronous): tables read as zero at once, registers return to defaults.
// ----------------------------------------------------------------------------
// linear_output_estimator_top: linear output estimator
// Slot tables in memories, multiply-accumulate pipe and result check.
// ----------------------------------------------------------------------------
module linear_output_estimator_top import loe_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [VAL_W-1:0]     csr_data
);

   localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [VAL_W-1:0] time_coeff_ff;
   thr_type          thr_ff;
   logic             in_pass_ff;
   logic [VAL_W-1:0] prev_output_ff;
   logic [VAL_W-1:0] last_time_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             adv;
   logic             accept;
   logic             is_elem;
   logic             in_range;
   logic [8:0]       slot_wide;
   logic [ADDR_W-1:0] slot_idx;
   elem_type         elem;
   logic [VAL_W-1:0] coeff_rd;
   logic [VAL_W-1:0] prev_rd;
   close_type        close;
   logic             res_valid;
   rsp_type          res;

   // hold the whole pipe only when a result cannot leave
   assign adv       = !res_valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign csr_ready = 1'b1;

   // decode the incoming transaction
   assign is_elem   = (req_data.command == CMD_EST) || (req_data.command == CMD_UPD);
   assign slot_wide = 9'(req_data.slot);
   assign in_range  = slot_wide < 9'(NUM_SLOTS);
   assign slot_idx  = slot_wide[ADDR_W-1:0];

   assign elem.valid    = accept && is_elem;
   assign elem.first    = !in_pass_ff;
   assign elem.in_range = in_range;
   assign elem.upd      = req_data.command == CMD_UPD;
   assign elem.last     = req_data.last;
   assign elem.dep      = req_data.dep_value;
   assign elem.meas     = req_data.measured;
   assign elem.prev_out = prev_output_ff;
   assign elem.elapsed  = req_data.time_now - last_time_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_coeff_ff     <= TIME_COEFF_RST;
         thr_ff.abs_thresh <= ABS_THRESH_RST;
         thr_ff.rel_thresh <= REL_THRESH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIME_COEFF: time_coeff_ff     <= csr_data;
            CSR_ABS_THRESH: thr_ff.abs_thresh <= csr_data[ABS_W-1:0];
            CSR_REL_THRESH: thr_ff.rel_thresh <= csr_data[REL_W-1:0];
            default: ;
         endcase
      end
   end

   // pass tracking; an update close stores the measurement and time
   always_ff @(posedge clock) begin
      if (reset) begin
         in_pass_ff     <= 1'b0;
         prev_output_ff <= '0;
         last_time_ff   <= '0;
      end else if (accept && is_elem) begin
         in_pass_ff <= !req_data.last;
         if (elem.upd && req_data.last) begin
            prev_output_ff <= req_data.measured;
            last_time_ff   <= req_data.time_now;
         end
      end
   end

   // coefficient table, written by load transactions
   loe_slot_mem #(
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_coeff_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (slot_idx),
      .rd_data (coeff_rd),
      .wr_en   (accept && (req_data.command == CMD_LOAD) && in_range),
      .wr_addr (slot_idx),
      .wr_data (req_data.coefficient)
   );

   // previous slot values, written by update elements
   loe_slot_mem #(
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_prev_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (slot_idx),
      .rd_data (prev_rd),
      .wr_en   (accept && elem.upd && in_range),
      .wr_addr (slot_idx),
      .wr_data (req_data.dep_value)
   );

   loe_accum #(
      .FRAC_BITS (FRAC_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .elem       (elem),
      .coeff_rd   (coeff_rd),
      .prev_rd    (prev_rd),
      .time_coeff (time_coeff_ff),
      .close      (close)
   );

   loe_judge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_judge (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .close     (close),
      .thr       (thr_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register: load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && adv) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // input is held back only by a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && res_valid))
      else $error("input stalled without output backpressure");

   a_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   a_est_no_mismatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind == KIND_EST)) |-> !rsp_data_ff.mismatch)
      else $error("mismatch flagged on an estimate result");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("waiting result dropped");
`endif

endmodule
`default_nettype wire

### hdl/loe_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// loe_slot_mem: per-slot table with zero reset
// One write and one registered read port; read returns the old entry on a
// same-address write. Valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module loe_slot_mem import loe_pkg::*; #(
   parameter int DEPTH  = DEF_NUM_SLOTS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [VAL_W-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [VAL_W-1:0]  wr_data
);

   logic [VAL_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [VAL_W-1:0] rd_data_ff;

   // write the array and read the old entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // track written entries; reset marks all as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/loe_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// loe_accum: multiply and accumulate pipe
// Stage one forms the element and time products, stage two folds the element
// product into the running accumulator and hands a closing record onward.
// ----------------------------------------------------------------------------
module loe_accum import loe_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire elem_type         elem,
   input  wire logic [VAL_W-1:0] coeff_rd,
   input  wire logic [VAL_W-1:0] prev_rd,
   input  wire logic [VAL_W-1:0] time_coeff,
   output close_type             close
);

   elem_type                 s1_ff;
   elem_type                 s2_ff;
   logic [ACC_W-1:0]         eprod_ff;
   logic [ACC_W-1:0]         tprod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   close_type                close_ff;

   logic signed [VAL_W:0]    change;
   logic signed [VAL_W:0]    elapsed_s;
   logic signed [2*VAL_W:0]  eprod_full;
   logic signed [2*VAL_W:0]  tprod_full;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  addend;

   // stage one: value change times coefficient, elapsed ticks times rate
   assign change     = $signed({s1_ff.dep[VAL_W-1], s1_ff.dep})
                     - $signed({prev_rd[VAL_W-1], prev_rd});
   assign elapsed_s  = $signed({1'b0, s1_ff.elapsed});
   assign eprod_full = change * $signed(coeff_rd);
   assign tprod_full = $signed(time_coeff) * elapsed_s;

   // stage two: start from the previous output on a new pass, then add
   assign base   = s2_ff.first ? (ACC_W'($signed(s2_ff.prev_out)) <<< FRAC_BITS) : acc_ff;
   assign addend = s2_ff.in_range ? $signed(eprod_ff) : '0;
   assign acc_in = sat_add(base, addend);

   // advance pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid    <= 1'b0;
         s2_ff.valid    <= 1'b0;
         close_ff.valid <= 1'b0;
         acc_ff         <= '0;
      end else if (adv) begin
         s1_ff.valid    <= elem.valid;
         s2_ff.valid    <= s1_ff.valid;
         close_ff.valid <= s2_ff.valid && s2_ff.last;
         if (s2_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   // advance pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff.first    <= elem.first;
         s1_ff.in_range <= elem.in_range;
         s1_ff.upd      <= elem.upd;
         s1_ff.last     <= elem.last;
         s1_ff.dep      <= elem.dep;
         s1_ff.meas     <= elem.meas;
         s1_ff.prev_out <= elem.prev_out;
         s1_ff.elapsed  <= elem.elapsed;

         s2_ff.first    <= s1_ff.first;
         s2_ff.in_range <= s1_ff.in_range;
         s2_ff.upd      <= s1_ff.upd;
         s2_ff.last     <= s1_ff.last;
         s2_ff.dep      <= s1_ff.dep;
         s2_ff.meas     <= s1_ff.meas;
         s2_ff.prev_out <= s1_ff.prev_out;
         s2_ff.elapsed  <= s1_ff.elapsed;
         eprod_ff       <= eprod_full[ACC_W-1:0];
         tprod_ff       <= tprod_full[ACC_W-1:0];

         close_ff.upd   <= s2_ff.upd;
         close_ff.meas  <= s2_ff.meas;
         close_ff.acc   <= acc_in;
         close_ff.tprod <= tprod_ff;
      end
   end

   assign close = close_ff;

endmodule
`default_nettype wire

### hdl/loe_judge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// loe_judge: final estimate and mismatch check
// Adds the time term on estimate closes, scales and clamps the estimate,
// then compares it with the measurement over two more stages.
// ----------------------------------------------------------------------------
module loe_judge import loe_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      adv,
   input  wire close_type close,
   input  wire thr_type   thr,
   output logic           res_valid,
   output rsp_type        res
);

   // stage four record
   logic                s4_valid_ff;
   logic                s4_upd_ff;
   logic [VAL_W-1:0]    s4_pred_ff;
   logic [VAL_W-1:0]    s4_meas_ff;
   // stage five record
   logic                s5_valid_ff;
   logic                s5_upd_ff;
   logic [VAL_W-1:0]    s5_pred_ff;
   logic [VAL_W:0]      s5_diff_ff;
   logic [VAL_W-1:0]    s5_big_ff;

   logic signed [ACC_W-1:0] final_acc;
   logic signed [ACC_W-1:0] shifted;
   logic [VAL_W-1:0]        pred_in;
   logic signed [VAL_W:0]   diff_s;
   logic [VAL_W:0]          diff_in;
   logic [VAL_W-1:0]        mag_pred;
   logic [VAL_W-1:0]        mag_meas;
   logic [VAL_W-1:0]        big_in;
   logic [VAL_W+REL_W:0]    lhs;
   logic [VAL_W+REL_W:0]    rhs;
   logic                    mismatch;

   // add time term, shift down with floor, clamp to output range
   always_comb begin
      final_acc = close.upd ? $signed(close.acc)
                            : sat_add($signed(close.acc), $signed(close.tprod));
      shifted   = final_acc >>> FRAC_BITS;
      if (shifted > OUT_MAX) begin
         pred_in = OUT_MAX[VAL_W-1:0];
      end else if (shifted < OUT_MIN) begin
         pred_in = OUT_MIN[VAL_W-1:0];
      end else begin
         pred_in = shifted[VAL_W-1:0];
      end
   end

   // absolute error and larger magnitude
   always_comb begin
      diff_s   = $signed({s4_pred_ff[VAL_W-1], s4_pred_ff})
               - $signed({s4_meas_ff[VAL_W-1], s4_meas_ff});
      diff_in  = diff_s[VAL_W] ? (VAL_W+1)'(-diff_s) : diff_s;
      mag_pred = s4_pred_ff[VAL_W-1] ? VAL_W'(-s4_pred_ff) : s4_pred_ff;
      mag_meas = s4_meas_ff[VAL_W-1] ? VAL_W'(-s4_meas_ff) : s4_meas_ff;
      big_in   = (mag_pred > mag_meas) ? mag_pred : mag_meas;
   end

   // relative test as multiply compare
   assign lhs      = {s5_diff_ff, {REL_W{1'b0}}};
   assign rhs      = (VAL_W+REL_W+1)'(thr.rel_thresh) * (VAL_W+REL_W+1)'(s5_big_ff);
   assign mismatch = s5_upd_ff && (s5_diff_ff > (VAL_W+1)'(thr.abs_thresh)) && (lhs > rhs);

   // advance valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= close.valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_upd_ff  <= close.upd;
         s4_pred_ff <= pred_in;
         s4_meas_ff <= close.meas;
         s5_upd_ff  <= s4_upd_ff;
         s5_pred_ff <= s4_pred_ff;
         s5_diff_ff <= diff_in;
         s5_big_ff  <= big_in;
      end
   end

   assign res_valid    = s5_valid_ff;
   assign res.kind     = s5_upd_ff ? KIND_UPD : KIND_EST;
   assign res.estimate = s5_pred_ff;
   assign res.mismatch = mismatch;

endmodule
`default_nettype wire
